// ===== sv/sqrr_pkg.sv =====
// shared types, codes and helpers of the slice quota round robin scheduler
package sqrr_pkg;

	localparam int THREAD_SLOTS_DEF = 8;
	localparam int OP_W             = 3;
	localparam int IDX_W            = 4;
	localparam int PRIO_W           = 8;
	localparam int CODE_W           = 2;
	localparam int TICK_W           = 32;
	localparam int LOCK_W           = 8;
	localparam int SLICE_W          = 7;
	localparam int QUEUE_DEPTH      = 2;
	localparam int QPTR_W           = 1;
	localparam int QCNT_W           = 2;

	localparam logic [OP_W-1:0] OP_TICK    = 3'd0;
	localparam logic [OP_W-1:0] OP_YIELD   = 3'd1;
	localparam logic [OP_W-1:0] OP_ALLOC   = 3'd2;
	localparam logic [OP_W-1:0] OP_SETPRIO = 3'd3;
	localparam logic [OP_W-1:0] OP_LOCK    = 3'd4;
	localparam logic [OP_W-1:0] OP_UNLOCK  = 3'd5;

	localparam logic [CODE_W-1:0] RES_OK    = 2'd0;
	localparam logic [CODE_W-1:0] RES_NORUN = 2'd1;
	localparam logic [CODE_W-1:0] RES_BAD   = 2'd2;

	localparam logic [PRIO_W-1:0] PRIO_FREE = 8'hFF;
	localparam logic [PRIO_W-1:0] PRIO_BOOT = 8'h01;

	typedef enum logic [2:0] {
		CMD_TICK,
		CMD_YIELD,
		CMD_ALLOC,
		CMD_SET,
		CMD_BADSET,
		CMD_LOCK,
		CMD_UNLOCK,
		CMD_NOP
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t          kind;
		logic [IDX_W-1:0]   idx;
		logic [PRIO_W-1:0]  prio;
	} cmd_t;

	typedef struct packed {
		logic valid;
		cmd_t cmd;
	} cmd_if_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_ALLOC
	} sqrr_state_t;

	function automatic logic is_runnable(input logic [PRIO_W-1:0] v);
		return (v != '0) && !v[PRIO_W-1];
	endfunction

endpackage

// ===== sv/slice_quota_round_robin_scheduler_core.sv =====
// top level of the slice quota round robin scheduler
//
// channel   direction  handshake                      payload
// command   in         push / full  (push & !full)    opcode, slot_index, priority_value
// result    out        pop / empty  (pop & !empty)    result_code, chosen_slot, systick_value
//
// set priority, lock, unlock and unused opcodes finish without a search; a tick or yield
// that keeps the running slot also does, otherwise the reschedule scan reads one
// slot per cycle, up to THREAD_SLOTS slots; allocate searches the same way
// a result stays held until popped; the engine starts the next command only after that,
// while a two-entry command queue keeps taking beats
// after reset slot 0 holds priority 1, the rest are inactive, all counters are zero
module slice_quota_round_robin_scheduler_core #(
	parameter int THREAD_SLOTS = sqrr_pkg::THREAD_SLOTS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                push,
	output logic                                full,
	input  logic [sqrr_pkg::OP_W-1:0]           opcode,
	input  logic [sqrr_pkg::IDX_W-1:0]          slot_index,
	input  logic signed [sqrr_pkg::PRIO_W-1:0]  priority_value,
	output logic                                empty,
	input  logic                                pop,
	output logic [sqrr_pkg::CODE_W-1:0]         result_code,
	output logic [sqrr_pkg::IDX_W-1:0]          chosen_slot,
	output logic [sqrr_pkg::TICK_W-1:0]         systick_value
);
	import sqrr_pkg::*;

	cmd_if_t cmd;
	logic    cmd_take;

	sqrr_front #(
		.THREAD_SLOTS(THREAD_SLOTS)
	) u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.push           (push),
		.full           (full),
		.opcode         (opcode),
		.slot_index     (slot_index),
		.priority_value (priority_value),
		.cmd_o          (cmd),
		.cmd_take       (cmd_take)
	);

	sqrr_back #(
		.THREAD_SLOTS(THREAD_SLOTS)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd_i         (cmd),
		.cmd_take      (cmd_take),
		.empty         (empty),
		.pop           (pop),
		.result_code   (result_code),
		.chosen_slot   (chosen_slot),
		.systick_value (systick_value)
	);

endmodule

// ===== sv/sqrr_front.sv =====
// front end: takes input beats, classifies them and queues commands for the engine
module sqrr_front #(
	parameter int THREAD_SLOTS = sqrr_pkg::THREAD_SLOTS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                push,
	output logic                                full,
	input  logic [sqrr_pkg::OP_W-1:0]           opcode,
	input  logic [sqrr_pkg::IDX_W-1:0]          slot_index,
	input  logic signed [sqrr_pkg::PRIO_W-1:0]  priority_value,
	output sqrr_pkg::cmd_if_t                   cmd_o,
	input  logic                                cmd_take
);
	import sqrr_pkg::*;

	cmd_t               q_mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]  wr_ptr_q;
	logic [QPTR_W-1:0]  rd_ptr_q;
	logic [QCNT_W-1:0]  cnt_q;
	cmd_t               cmd_in;
	logic               accept;
	logic               idx_ok;

	assign full   = (cnt_q == QCNT_W'(QUEUE_DEPTH));
	assign accept = push && !full;
	assign idx_ok = ({1'b0, slot_index} < (IDX_W+1)'(THREAD_SLOTS));

	always_comb begin
		cmd_in.idx  = slot_index;
		cmd_in.prio = priority_value;
		case (opcode)
			OP_TICK:    cmd_in.kind = CMD_TICK;
			OP_YIELD:   cmd_in.kind = CMD_YIELD;
			OP_ALLOC:   cmd_in.kind = CMD_ALLOC;
			OP_SETPRIO: cmd_in.kind = idx_ok ? CMD_SET : CMD_BADSET;
			OP_LOCK:    cmd_in.kind = CMD_LOCK;
			OP_UNLOCK:  cmd_in.kind = CMD_UNLOCK;
			default:    cmd_in.kind = CMD_NOP;
		endcase
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			q_mem_q[wr_ptr_q] <= cmd_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (accept) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (cmd_take) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({accept, cmd_take})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	assign cmd_o.valid = (cnt_q != '0);
	assign cmd_o.cmd   = q_mem_q[rd_ptr_q];

	a_take_needs_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_take |-> cmd_o.valid)
		else $error("engine took a command from an empty queue");

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= QCNT_W'(QUEUE_DEPTH))
		else $error("command queue count out of range");

	a_cnt_grow: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !cmd_take) |=> (cnt_q == $past(cnt_q) + 1'b1))
		else $error("accepted beat not counted");

endmodule

// ===== sv/sqrr_back.sv =====
// back end: executes queued commands, scans the slot table and holds the result
module sqrr_back #(
	parameter int THREAD_SLOTS = sqrr_pkg::THREAD_SLOTS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  sqrr_pkg::cmd_if_t             cmd_i,
	output logic                          cmd_take,
	output logic                          empty,
	input  logic                          pop,
	output logic [sqrr_pkg::CODE_W-1:0]   result_code,
	output logic [sqrr_pkg::IDX_W-1:0]    chosen_slot,
	output logic [sqrr_pkg::TICK_W-1:0]   systick_value
);
	import sqrr_pkg::*;

	localparam int SLOT_W = $clog2(THREAD_SLOTS);
	localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(THREAD_SLOTS - 1);

	sqrr_state_t          state_q, state_d;
	logic [PRIO_W-1:0]    prio_q [THREAD_SLOTS];
	logic [SLOT_W-1:0]    cur_q, cur_d;
	logic [SLOT_W-1:0]    cnt_q, cnt_d;
	logic [SLICE_W-1:0]   slice_q, slice_d, slice_dec;
	logic [LOCK_W-1:0]    lock_q, lock_d;
	logic [TICK_W-1:0]    tick_q, tick_d;

	logic                 res_valid_q;
	logic [CODE_W-1:0]    res_code_q;
	logic [IDX_W-1:0]     res_slot_q;
	logic [TICK_W-1:0]    res_tick_q;

	logic                 start;
	logic                 locked;
	logic                 keep_tick;
	logic [SLOT_W-1:0]    next_cur;
	logic [SLOT_W-1:0]    rd_idx;
	logic [PRIO_W-1:0]    rd_prio;
	logic                 last;
	logic                 scan_hit;
	logic                 free_hit;

	logic                 res_load;
	logic [CODE_W-1:0]    res_code;
	logic [IDX_W-1:0]     res_slot;
	logic                 prio_we;
	logic [SLOT_W-1:0]    prio_widx;
	logic [PRIO_W-1:0]    prio_wdata;

	assign start     = (state_q == ST_IDLE) && cmd_i.valid && !res_valid_q;
	assign locked    = is_runnable(lock_q);
	assign slice_dec = slice_q - SLICE_W'(slice_q != '0);
	assign keep_tick = locked || (slice_dec != '0);
	assign next_cur  = (cur_q == LAST_SLOT) ? '0 : cur_q + 1'b1;
	// one read port shared by the reschedule scan and the allocate search
	assign rd_idx    = (state_q == ST_ALLOC) ? cnt_q : next_cur;
	assign rd_prio   = prio_q[rd_idx];
	assign last      = (cnt_q == LAST_SLOT);
	assign scan_hit  = is_runnable(rd_prio);
	assign free_hit  = (rd_prio == PRIO_FREE);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					case (cmd_i.cmd.kind)
						CMD_TICK:  state_d = keep_tick ? ST_IDLE : ST_SCAN;
						CMD_YIELD: state_d = locked ? ST_IDLE : ST_SCAN;
						CMD_ALLOC: state_d = ST_ALLOC;
						default:   state_d = ST_IDLE;
					endcase
				end
			end
			ST_SCAN:  state_d = (scan_hit || last) ? ST_IDLE : ST_SCAN;
			ST_ALLOC: state_d = (free_hit || last) ? ST_IDLE : ST_ALLOC;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd_take   = 1'b0;
		res_load   = 1'b0;
		res_code   = RES_OK;
		res_slot   = IDX_W'(cur_q);
		prio_we    = 1'b0;
		prio_widx  = cnt_q;
		prio_wdata = cmd_i.cmd.prio;
		cur_d      = cur_q;
		cnt_d      = cnt_q;
		slice_d    = slice_q;
		lock_d     = lock_q;
		tick_d     = tick_q;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd_take = 1'b1;
					cnt_d    = '0;
					case (cmd_i.cmd.kind)
						CMD_TICK: begin
							tick_d = tick_q + 1'b1;
							if (!locked) begin
								slice_d = slice_dec;
							end
							res_load = keep_tick;
						end
						CMD_YIELD: begin
							slice_d  = '0;
							res_load = locked;
						end
						CMD_ALLOC: begin
						end
						CMD_SET: begin
							prio_we   = 1'b1;
							prio_widx = cmd_i.cmd.idx[SLOT_W-1:0];
							res_load  = 1'b1;
							res_slot  = cmd_i.cmd.idx;
						end
						CMD_BADSET: begin
							res_load = 1'b1;
							res_code = RES_BAD;
							res_slot = '0;
						end
						CMD_LOCK: begin
							lock_d   = lock_q + 1'b1;
							res_load = 1'b1;
						end
						CMD_UNLOCK: begin
							lock_d   = lock_q - 1'b1;
							res_load = 1'b1;
						end
						default: begin
							res_load = 1'b1;
						end
					endcase
				end
			end
			ST_SCAN: begin
				// current slot walks with the scan and lands back on start if nothing runs
				cur_d    = next_cur;
				res_slot = IDX_W'(next_cur);
				cnt_d    = cnt_q + 1'b1;
				if (scan_hit) begin
					slice_d  = rd_prio[SLICE_W-1:0];
					res_load = 1'b1;
				end else if (last) begin
					res_load = 1'b1;
					res_code = RES_NORUN;
				end
			end
			ST_ALLOC: begin
				cnt_d = cnt_q + 1'b1;
				if (free_hit) begin
					prio_we    = 1'b1;
					prio_wdata = '0;
					res_load   = 1'b1;
					res_slot   = IDX_W'(cnt_q);
				end else if (last) begin
					res_load = 1'b1;
					res_code = RES_BAD;
					res_slot = '0;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cur_q   <= '0;
			cnt_q   <= '0;
			slice_q <= '0;
			lock_q  <= '0;
			tick_q  <= '0;
			for (int i = 0; i < THREAD_SLOTS; i++) begin
				prio_q[i] <= (i == 0) ? PRIO_BOOT : PRIO_FREE;
			end
		end else begin
			state_q <= state_d;
			cur_q   <= cur_d;
			cnt_q   <= cnt_d;
			slice_q <= slice_d;
			lock_q  <= lock_d;
			tick_q  <= tick_d;
			if (prio_we) begin
				prio_q[prio_widx] <= prio_wdata;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (res_load) begin
			res_valid_q <= 1'b1;
		end else if (pop) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			res_code_q <= res_code;
			res_slot_q <= res_slot;
			res_tick_q <= tick_d;
		end
	end

	assign empty         = !res_valid_q;
	assign result_code   = res_code_q;
	assign chosen_slot   = res_slot_q;
	assign systick_value = res_tick_q;

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		res_load |-> !res_valid_q)
		else $error("result beat overwritten before pop");

	a_busy_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> !res_valid_q)
		else $error("search running while a result waits");

	a_take_in_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_take |=> ($past(state_q) == ST_IDLE))
		else $error("command taken outside idle");

	a_scan_loads_slice: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN && scan_hit) |=> (slice_q != '0 && res_valid_q))
		else $error("scan hit left no slice quota");

endmodule
